// ----- hw/rtl/fdt_pkg.sv -----
package fdt_pkg;

    // Defaults for the top-level parameters.
    localparam int CoordBitsDef = 12;
    localparam int FracBitsDef  = 16;

    // Fixed port geometry.
    localparam int FieldCoordW = 12;
    localparam int CoordMaxW   = 16;
    localparam int InDataW     = 88;
    localparam int OutDataW    = 32;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 64;

    // Depth of the queue between front and back.
    localparam int QueueDepth = 4;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] RegCoefA   = 3'd0;
    localparam logic [CfgIdxW-1:0] RegCoefB   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegCoefC   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCoefD   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegCoefE   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegCoefF   = 3'd5;
    localparam logic [CfgIdxW-1:0] RegFloor   = 3'd6;
    localparam logic [CfgIdxW-1:0] RegCeiling = 3'd7;

    localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32Min = 32'sh8000_0000;

    // Homography and baseline, each signed fixed point.
    typedef struct packed {
        logic signed [31:0] h00;
        logic signed [31:0] h01;
        logic signed [31:0] h02;
        logic signed [31:0] h10;
        logic signed [31:0] h11;
        logic signed [31:0] h12;
        logic signed [31:0] h20;
        logic signed [31:0] h21;
        logic signed [31:0] h22;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] b3;
    } t_coefs;

    // One division job: sign and magnitude of the numerator, and the denominator.
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
        logic [63:0] den;
    } t_div_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
        logic signed [31:0] r;
        if (v > 96'(S32Max)) begin
            r = S32Max;
        end else if (v < 96'(S32Min)) begin
            r = S32Min;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/fdt_front.sv -----
module fdt_front #(
    parameter int COORD_BITS = fdt_pkg::CoordBitsDef,
    parameter int FRAC_BITS  = fdt_pkg::FracBitsDef
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [fdt_pkg::FieldCoordW-1:0]      i_col,
    input  logic [fdt_pkg::FieldCoordW-1:0]      i_row,
    input  logic signed [31:0]                   i_dx,
    input  logic signed [31:0]                   i_dy,
    input  fdt_pkg::t_coefs                      i_coef,
    output logic                                 o_push,
    output fdt_pkg::t_div_job                    o_job,
    input  fdt_pkg::t_q_stat                     i_qstat
);
    import fdt_pkg::*;

    localparam int XW = COORD_BITS + 1;
    localparam int PW = 32 + XW;
    localparam int AW = ((COORD_BITS + FRAC_BITS) > 32 ? COORD_BITS + FRAC_BITS : 32) + 2;
    localparam logic signed [64:0] Half = 65'sd1 <<< (FRAC_BITS - 1);
    localparam int NStg = 7;

    logic [NStg-1:0] r_v;
    logic            w_en;

    // The whole front moves together; it holds only when its last stage cannot enter the queue.
    assign w_en    = !r_v[NStg-1] || !i_qstat.full;
    assign o_ready = w_en;
    assign o_push  = r_v[NStg-1] && !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NStg-2:0], i_valid};
        end
    end

    // Stage 1: coordinate products and matched position.
    logic [CoordMaxW-1:0]   w_col16, w_row16;
    logic [COORD_BITS-1:0]  w_x, w_y;
    logic signed [XW-1:0]   w_xs, w_ys;
    logic signed [AW-1:0]   w_a1, w_a2;
    logic signed [PW-1:0]   r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    logic signed [31:0]     r_a1, r_a2;

    assign w_col16 = CoordMaxW'(i_col);
    assign w_row16 = CoordMaxW'(i_row);
    assign w_x     = w_col16[COORD_BITS-1:0];
    assign w_y     = w_row16[COORD_BITS-1:0];
    assign w_xs    = signed'({1'b0, w_x});
    assign w_ys    = signed'({1'b0, w_y});
    assign w_a1    = signed'(AW'({w_x, {FRAC_BITS{1'b0}}})) + AW'(i_dx);
    assign w_a2    = signed'(AW'({w_y, {FRAC_BITS{1'b0}}})) + AW'(i_dy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p00 <= i_coef.h00 * w_xs;
            r_p01 <= i_coef.h01 * w_ys;
            r_p10 <= i_coef.h10 * w_xs;
            r_p11 <= i_coef.h11 * w_ys;
            r_p20 <= i_coef.h20 * w_xs;
            r_p21 <= i_coef.h21 * w_ys;
            r_a1  <= sat32(96'(w_a1));
            r_a2  <= sat32(96'(w_a2));
        end
    end

    // Stage 2: mapped point w = H*[x y 1].
    logic signed [31:0] r_w1, r_w2, r_w3, r2_a1, r2_a2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w1  <= sat32(96'(r_p00) + 96'(r_p01) + 96'(i_coef.h02));
            r_w2  <= sat32(96'(r_p10) + 96'(r_p11) + 96'(i_coef.h12));
            r_w3  <= sat32(96'(r_p20) + 96'(r_p21) + 96'(i_coef.h22));
            r2_a1 <= r_a1;
            r2_a2 <= r_a2;
        end
    end

    // Stage 3: full-width fixed-point products.
    logic signed [63:0] r_m1, r_m2, r_m3, r_m4;
    logic signed [31:0] r3_w1, r3_w2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1  <= r2_a1 * r_w3;
            r_m2  <= r2_a2 * r_w3;
            r_m3  <= r2_a1 * i_coef.b3;
            r_m4  <= r2_a2 * i_coef.b3;
            r3_w1 <= r_w1;
            r3_w2 <= r_w2;
        end
    end

    // Stage 4: round half up, drop the fraction, saturate.
    logic signed [64:0] w_t1, w_t2, w_t3, w_t4;
    logic signed [31:0] r_f1, r_f2, r_f3, r_f4, r4_w1, r4_w2;

    assign w_t1 = (65'(r_m1) + Half) >>> FRAC_BITS;
    assign w_t2 = (65'(r_m2) + Half) >>> FRAC_BITS;
    assign w_t3 = (65'(r_m3) + Half) >>> FRAC_BITS;
    assign w_t4 = (65'(r_m4) + Half) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1  <= sat32(96'(w_t1));
            r_f2  <= sat32(96'(w_t2));
            r_f3  <= sat32(96'(w_t3));
            r_f4  <= sat32(96'(w_t4));
            r4_w1 <= r3_w1;
            r4_w2 <= r3_w2;
        end
    end

    // Stage 5: residuals e and n.
    logic signed [31:0] r_e1, r_e2, r_n1, r_n2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1 <= sat32(96'(r4_w1) - 96'(r_f1));
            r_e2 <= sat32(96'(r4_w2) - 96'(r_f2));
            r_n1 <= sat32(96'(r_f3) - 96'(i_coef.b1));
            r_n2 <= sat32(96'(r_f4) - 96'(i_coef.b2));
        end
    end

    // Stage 6: dot-product terms.
    logic signed [63:0] r_q1, r_q2, r_s1, r_s2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q1 <= r_n1 * r_e1;
            r_q2 <= r_n2 * r_e2;
            r_s1 <= r_e1 * r_e1;
            r_s2 <= r_e2 * r_e2;
        end
    end

    // Stage 7: numerator as sign and magnitude, denominator.
    logic signed [64:0] w_num;
    logic [64:0]        w_abs;
    t_div_job           r_job;

    assign w_num = 65'(r_q1) + 65'(r_q2);
    assign w_abs = w_num[64] ? 65'(-w_num) : 65'(w_num);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_job.neg <= w_num[64];
            r_job.mag <= w_abs[63:0];
            r_job.den <= 64'(r_s1) + 64'(r_s2);
        end
    end

    assign o_job = r_job;

endmodule

// ----- hw/rtl/fdt_queue.sv -----
module fdt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fdt_pkg::t_div_job i_job,
    input  logic              i_pop,
    output fdt_pkg::t_div_job o_job,
    output fdt_pkg::t_q_stat  o_stat
);
    import fdt_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    t_div_job          r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wp, r_rp;
    logic [PtrW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PtrW+1)'(i_push) - (PtrW+1)'(i_pop);
        end
    end

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (PtrW+1)'(QueueDepth));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ----- hw/rtl/fdt_back.sv -----
module fdt_back #(
    parameter int FRAC_BITS = fdt_pkg::FracBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fdt_pkg::t_q_stat   i_qstat,
    input  fdt_pkg::t_div_job  i_job,
    output logic               o_pop,
    input  logic signed [31:0] i_floor,
    input  logic signed [31:0] i_ceiling,
    output logic               o_valid,
    output logic signed [31:0] o_depth,
    input  logic               i_ready
);
    import fdt_pkg::*;

    localparam int Sh   = 31 - FRAC_BITS;
    localparam int NDiv = 31;

    logic w_en;

    assign w_en  = !o_valid || i_ready;
    assign o_pop = w_en && !i_qstat.empty;

    logic [NDiv:0]  r_v;
    logic           r_neg  [NDiv+1];
    logic           r_den0 [NDiv+1];
    logic           r_ovf  [NDiv+1];
    logic           r_mnz  [NDiv+1];
    logic [63:0]    r_mag  [NDiv+1];
    logic [63:0]    r_den  [NDiv+1];
    logic [63:0]    r_rem  [NDiv+1];
    logic [NDiv-1:0] r_q   [NDiv+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NDiv-1:0], !i_qstat.empty};
        end
    end

    // Entry stage: special cases and the quotient range check.
    logic [63+Sh:0] w_mag_x, w_lim;

    assign w_mag_x = (64+Sh)'(i_job.mag);
    assign w_lim   = (64+Sh)'(i_job.den) << Sh;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_neg[0]  <= i_job.neg;
            r_den0[0] <= (i_job.den == '0);
            r_ovf[0]  <= (w_mag_x >= w_lim);
            r_mnz[0]  <= (i_job.mag != '0);
            r_mag[0]  <= i_job.mag;
            r_den[0]  <= i_job.den;
            r_rem[0]  <= i_job.mag >> Sh;
            r_q[0]    <= '0;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k <= NDiv; k++) begin : g_div
        localparam int Bi = NDiv - k;
        logic        w_bit;
        logic [64:0] w_try;
        logic        w_ge;

        if (Bi >= FRAC_BITS) begin : g_mb
            assign w_bit = r_mag[k-1][Bi-FRAC_BITS];
        end else begin : g_zb
            assign w_bit = 1'b0;
        end

        assign w_try = {r_rem[k-1], w_bit};
        assign w_ge  = (w_try >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_neg[k]  <= r_neg[k-1];
                r_den0[k] <= r_den0[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_mnz[k]  <= r_mnz[k-1];
                r_mag[k]  <= r_mag[k-1];
                r_den[k]  <= r_den[k-1];
                r_rem[k]  <= w_ge ? 64'(w_try - {1'b0, r_den[k-1]}) : w_try[63:0];
                r_q[k]    <= {r_q[k-1][NDiv-2:0], w_ge};
            end
        end
    end

    // Output stage: sign, saturation, clamp.
    logic signed [31:0] w_qs, w_lo, w_res;

    always_comb begin
        priority if (r_den0[NDiv]) begin
            w_qs = (!r_neg[NDiv] && r_mnz[NDiv]) ? S32Max : S32Min;
        end else if (r_ovf[NDiv]) begin
            w_qs = r_neg[NDiv] ? S32Min : S32Max;
        end else if (r_neg[NDiv]) begin
            w_qs = -signed'({1'b0, r_q[NDiv]});
        end else begin
            w_qs = signed'({1'b0, r_q[NDiv]});
        end
        w_lo  = (w_qs < i_floor) ? i_floor : w_qs;
        w_res = (w_lo > i_ceiling) ? i_ceiling : w_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_v[NDiv];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_depth <= w_res;
        end
    end

endmodule

// ----- hw/rtl/flow_depth_triangulation.sv -----
// An accepted input item passes the 7 front stages, the queue, then the 33 divider
// and output stages; throughput is one item per cycle while nothing stalls.
// The 31-stage restoring divider makes one quotient bit a stage.
// Reset (i_rst_n low at a clock edge, synchronous) empties the pipelines and the queue,
// zeroes the coefficient and floor registers and sets the ceiling to the largest value.
module flow_depth_triangulation #(
    parameter int COORD_BITS = fdt_pkg::CoordBitsDef,
    parameter int FRAC_BITS  = fdt_pkg::FracBitsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input item stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata from bit 0: pixel_col[12], pixel_row[12], flow_dx[32], flow_dy[32].
    input  logic [fdt_pkg::InDataW-1:0]    s_axis_tdata,
    // Result item stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata from bit 0: depth_out[32].
    output logic [fdt_pkg::OutDataW-1:0]   m_axis_tdata,
    // Configuration writes.
    input  logic                           i_cfg_we,
    input  logic [fdt_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [fdt_pkg::CfgDataW-1:0]   i_cfg_data
);
    import fdt_pkg::*;

    // Configuration registers. Each coefficient pair holds two signed values,
    // the first named in the upper half.
    logic [63:0]        r_ca, r_cb, r_cc, r_cd, r_ce, r_cf;
    logic signed [31:0] r_floor, r_ceiling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca      <= '0;
            r_cb      <= '0;
            r_cc      <= '0;
            r_cd      <= '0;
            r_ce      <= '0;
            r_cf      <= '0;
            r_floor   <= '0;
            r_ceiling <= S32Max;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegCoefA:   r_ca      <= i_cfg_data;
                RegCoefB:   r_cb      <= i_cfg_data;
                RegCoefC:   r_cc      <= i_cfg_data;
                RegCoefD:   r_cd      <= i_cfg_data;
                RegCoefE:   r_ce      <= i_cfg_data;
                RegCoefF:   r_cf      <= i_cfg_data;
                RegFloor:   r_floor   <= signed'(i_cfg_data[31:0]);
                RegCeiling: r_ceiling <= signed'(i_cfg_data[31:0]);
                default: begin
                end
            endcase
        end
    end

    t_coefs w_coef;

    assign w_coef.h00 = signed'(r_ca[63:32]);
    assign w_coef.h01 = signed'(r_ca[31:0]);
    assign w_coef.h02 = signed'(r_cb[63:32]);
    assign w_coef.h10 = signed'(r_cb[31:0]);
    assign w_coef.h11 = signed'(r_cc[63:32]);
    assign w_coef.h12 = signed'(r_cc[31:0]);
    assign w_coef.h20 = signed'(r_cd[63:32]);
    assign w_coef.h21 = signed'(r_cd[31:0]);
    assign w_coef.h22 = signed'(r_ce[63:32]);
    assign w_coef.b1  = signed'(r_ce[31:0]);
    assign w_coef.b2  = signed'(r_cf[63:32]);
    assign w_coef.b3  = signed'(r_cf[31:0]);

    // The front maps the pixel through H, forms the residuals and reduces them
    // to a numerator and denominator. It stalls only when the queue is full.
    logic     w_push, w_pop;
    t_div_job w_fjob, w_qjob;
    t_q_stat  w_qstat;

    fdt_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_col   (s_axis_tdata[11:0]),
        .i_row   (s_axis_tdata[23:12]),
        .i_dx    (signed'(s_axis_tdata[55:24])),
        .i_dy    (signed'(s_axis_tdata[87:56])),
        .i_coef  (w_coef),
        .o_push  (w_push),
        .o_job   (w_fjob),
        .i_qstat (w_qstat)
    );

    // A short queue decouples the front from the divider, so a stalled
    // result stream does not hold the front back until the queue fills.
    fdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_qstat)
    );

    // The back divides, handles a zero denominator and quotient overflow,
    // clamps to the configured bounds and holds the result in its output register.
    logic signed [31:0] w_depth;

    fdt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_qstat   (w_qstat),
        .i_job     (w_qjob),
        .o_pop     (w_pop),
        .i_floor   (r_floor),
        .i_ceiling (r_ceiling),
        .o_valid   (m_axis_tvalid),
        .o_depth   (w_depth),
        .i_ready   (m_axis_tready)
    );

    assign m_axis_tdata = w_depth;

    // The front only refuses items when its last stage is held by a full queue.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_qstat.full)
        else $error("input stalled while the queue had room");

    // The queue is never written while full or read while empty.
    a_queue_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full) && !(w_pop && w_qstat.empty))
        else $error("queue overrun or underrun");

    // With ordered bounds every delivered depth lies within them.
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_floor <= r_ceiling) |->
            (w_depth >= r_floor && w_depth <= r_ceiling))
        else $error("depth outside configured bounds");

    // No result appears in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
